### rtl/core/v2dc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2dc_pkg - shared types and constants of the 2D convolution unit
// Kernel geometry, field widths, register indexes and the word types of the
// pixel and result channels.
// ----------------------------------------------------------------------------
package v2dc_pkg;

  // Geometry
  localparam int KERNEL_SIZE = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int COEF_BITS   = 16;

  // Line memory: one word per column, one pixel lane per buffered row
  localparam int PIX_W   = 8;
  localparam int LB_ROWS = (KERNEL_SIZE > 1) ? KERNEL_SIZE - 1 : 1;
  localparam int LB_W    = LB_ROWS * PIX_W;
  localparam int ADDR_W  = $clog2(MAX_WIDTH);

  // Field and counter widths
  localparam int CNT_W     = 10;
  localparam int DIM_W     = 11;
  localparam int CONV_W    = 28;
  localparam int CFG_IDX_W = 3;

  // Coefficient registers
  localparam int COEF_REG_W    = 64;
  localparam int COEF_SLOT     = 16;
  localparam int NUM_COEF_ROWS = 4;

  // Arithmetic widths: unsigned pixel with a sign bit times coefficient,
  // then up to four products per row and up to four rows.
  localparam int PROD_W = PIX_W + 1 + COEF_BITS;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = ROW_W + 2;

  // Reset values of the size registers
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(64);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(64);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW3    = 3'd5;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             first_pixel;
  } pixel_word_t;

  typedef struct packed {
    logic signed [CONV_W-1:0] conv_value;
    logic [CNT_W-1:0]         out_row;
    logic [CNT_W-1:0]         out_col;
    logic                     last_of_image;
  } conv_word_t;

  // Output position carried alongside the arithmetic
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } pos_t;

  // Take one signed coefficient out of a packed kernel row
  function automatic logic signed [COEF_BITS-1:0] coef_at(
    input logic [COEF_REG_W-1:0] row_bits,
    input int unsigned           col
  );
    logic [COEF_SLOT-1:0] slot;
    slot = row_bits[COEF_SLOT*col +: COEF_SLOT];
    return slot[COEF_BITS-1:0];
  endfunction

endpackage

### rtl/core/valid_2d_convolution_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valid_2d_convolution_unit - valid 3x3 sliding-window convolution
// Raster pixel stream in, one signed Q.8 window sum per full window out.
// ----------------------------------------------------------------------------
// Usage:
//   pix     : pixel words in raster order, valid/stall handshake. first_pixel
//             forces the word to row 0, column 0; otherwise the position
//             wraps by itself at the end of each row and image.
//   res     : one result word per pixel that completes a window lying
//             fully inside the image, in row-major order, with its output
//             row and column and a flag on the last position of the image.
//   cfg     : register writes (index, data), always ready. Write only while
//             the block is idle.
//   Throughput: one pixel per clock while pix_stall is low, set by the single
//             line memory, which takes one read and one write each cycle.
//   Pipeline: after its pixel is accepted, a result passes the memory read,
//             window shift, multiply, row sums and final add into the output.
//   Reset: after rst falls, the line memory is cleared one column a cycle
//             with pix_stall held high; configuration
//             writes are taken during that sweep.
//   Stall: a result waiting on res_stall is held in the output register;
//             one more result parks in a skid register, and only then is
//             pix_stall raised and the pipeline frozen.
// ----------------------------------------------------------------------------
module valid_2d_convolution_unit import v2dc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pix_valid,
  output logic                  pix_stall,
  input  pixel_word_t           pix,
  output logic                  res_valid,
  input  logic                  res_stall,
  output conv_word_t            res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_REG_W-1:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]      image_width;
  logic [DIM_W-1:0]      image_height;
  logic [COEF_REG_W-1:0] coef_rows [NUM_COEF_ROWS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      for (int r = 0; r < NUM_COEF_ROWS; r++) begin
        coef_rows[r] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        CFG_COEF_ROW0:    coef_rows[0] <= cfg_data;
        CFG_COEF_ROW1:    coef_rows[1] <= cfg_data;
        CFG_COEF_ROW2:    coef_rows[2] <= cfg_data;
        CFG_COEF_ROW3:    coef_rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the sizes to the supported range
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;

  always_comb begin
    width_eff = image_width;
    if (image_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (image_width > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end
    height_eff = image_height;
    if (image_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid word is full
  // --------------------------------------------------------------------------
  logic clearing;
  logic skid_valid;
  logic advance;
  logic accept;

  assign advance   = !skid_valid;
  assign pix_stall = clearing || skid_valid;
  assign accept    = pix_valid && !pix_stall;

  // --------------------------------------------------------------------------
  // Line memory clearing sweep after reset
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + ADDR_W'(1);
      if (clear_addr == ADDR_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Position counters and accept-stage decode
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] col_count;
  logic [CNT_W-1:0] cur_row;
  logic [CNT_W-1:0] cur_col;
  logic             cur_emit;
  pos_t             cur_pos;
  logic             col_wrap;
  logic             row_wrap;

  always_comb begin
    cur_row  = pix.first_pixel ? '0 : row_count;
    cur_col  = pix.first_pixel ? '0 : col_count;
    cur_emit = (cur_row >= CNT_W'(KERNEL_SIZE - 1)) && (cur_col >= CNT_W'(KERNEL_SIZE - 1));
    cur_pos.row  = cur_row - CNT_W'(KERNEL_SIZE - 1);
    cur_pos.col  = cur_col - CNT_W'(KERNEL_SIZE - 1);
    cur_pos.last = ({1'b0, cur_row} == height_eff - DIM_W'(1)) &&
                   ({1'b0, cur_col} == width_eff - DIM_W'(1));
    col_wrap = ({1'b0, cur_col} + DIM_W'(1)) >= width_eff;
    row_wrap = ({1'b0, cur_row} + DIM_W'(1)) >= height_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : cur_row + CNT_W'(1);
      end else begin
        col_count <= cur_col + CNT_W'(1);
        row_count <= cur_row;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: read at accept, write back from the stage 1 registers later
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] rd_addr;
  logic [LB_W-1:0]   ram_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LB_W-1:0]   wr_data;
  logic [LB_W-1:0]   line_cur;
  logic [LB_W-1:0]   line_next;
  logic [PIX_W-1:0]  col_new [KERNEL_SIZE];

  // Stage 1 registers
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_px;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_emit;
  pos_t              s1_pos;
  logic              fwd_hit;
  logic [LB_W-1:0]   fwd_data;

  assign rd_addr = cur_col[ADDR_W-1:0];

  // Forward the word written in the same cycle as the read of that column
  assign line_cur = fwd_hit ? fwd_data : ram_q;

  // Shift the buffered rows up by one at this column; newest pixel on top
  always_comb begin
    for (int k = 0; k < LB_ROWS - 1; k++) begin
      line_next[k*PIX_W +: PIX_W] = line_cur[(k+1)*PIX_W +: PIX_W];
    end
    line_next[(LB_ROWS-1)*PIX_W +: PIX_W] = s1_px;
    for (int k = 0; k < KERNEL_SIZE - 1; k++) begin
      col_new[k] = line_cur[k*PIX_W +: PIX_W];
    end
    col_new[KERNEL_SIZE-1] = s1_px;
  end

  assign wr_en   = clearing || (advance && s1_valid);
  assign wr_addr = clearing ? clear_addr : s1_addr;
  assign wr_data = clearing ? '0 : line_next;

  v2dc_ram #(
    .WIDTH(LB_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (advance),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px    <= pix.pixel;
      s1_addr  <= rd_addr;
      s1_emit  <= cur_emit;
      s1_pos   <= cur_pos;
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: window registers, newest column on the right
  // --------------------------------------------------------------------------
  logic             s2_valid;
  pos_t             s2_pos;
  logic [PIX_W-1:0] window [KERNEL_SIZE][KERNEL_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pos <= s1_pos;
      if (s1_valid) begin
        for (int k = 0; k < KERNEL_SIZE; k++) begin
          for (int l = 0; l < KERNEL_SIZE - 1; l++) begin
            window[k][l] <= window[k][l+1];
          end
          window[k][KERNEL_SIZE-1] <= col_new[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: one multiplier per tap
  // --------------------------------------------------------------------------
  logic signed [COEF_BITS-1:0] coef [KERNEL_SIZE][KERNEL_SIZE];
  logic                        s3_valid;
  pos_t                        s3_pos;
  logic signed [PROD_W-1:0]    prod [KERNEL_SIZE][KERNEL_SIZE];

  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        coef[k][l] = coef_at(coef_rows[k], l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (advance) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_pos <= s2_pos;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        for (int l = 0; l < KERNEL_SIZE; l++) begin
          prod[k][l] <= PROD_W'($signed({1'b0, window[k][l]})) * PROD_W'(coef[k][l]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: per-row sums
  // --------------------------------------------------------------------------
  logic signed [ROW_W-1:0] row_sum_next [KERNEL_SIZE];
  logic signed [ROW_W-1:0] row_sum [KERNEL_SIZE];
  logic                    s4_valid;
  pos_t                    s4_pos;

  always_comb begin
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      row_sum_next[k] = '0;
      for (int l = 0; l < KERNEL_SIZE; l++) begin
        row_sum_next[k] = row_sum_next[k] + ROW_W'(prod[k][l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (advance) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_pos <= s3_pos;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        row_sum[k] <= row_sum_next[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final add and output register with skid word
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] total;
  conv_word_t              new_word;
  conv_word_t              skid_word;
  logic                    out_free;

  always_comb begin
    total = '0;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      total = total + SUM_W'(row_sum[k]);
    end
    new_word.conv_value    = CONV_W'(total);
    new_word.out_row       = s4_pos.row;
    new_word.out_col       = s4_pos.col;
    new_word.last_of_image = s4_pos.last;
  end

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // Drain the parked word first; the pipeline is frozen meanwhile
      if (out_free) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (s4_valid) begin
      if (out_free) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        res <= skid_word;
      end
    end else if (s4_valid) begin
      if (out_free) begin
        res <= new_word;
      end else begin
        skid_word <= new_word;
      end
    end
  end

endmodule

### rtl/core/v2dc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2dc_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module v2dc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the last read word while disabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/v2dc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2dc_checker - port-level checks of the 2D convolution unit
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module v2dc_checker import v2dc_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  pix_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input conv_word_t            res,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // A stalled result word holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed or dropped while stalled");

  // The line memory sweep keeps the pixel channel closed after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> pix_stall)
    else $error("pixel channel open right after reset");

  // Reset empties the result path
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result word presented right after reset");

  // Configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind valid_2d_convolution_unit v2dc_checker u_v2dc_checker (.*);
